### design/updt_pkg.sv
// ----------------------------------------------------------------------------
// updt_pkg
// Shared types, codes and helpers of the percent decoder with trimming.
// ----------------------------------------------------------------------------
package updt_pkg;

   localparam int MAX_SPACE_RUN_DEF = 32;
   localparam int SPC_W             = 6;      // holds any run length up to 63
   localparam int LEN_W             = 16;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_HEX   = 3'd1;
   localparam logic [2:0] ST_CUT_ESC   = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_SPACE_OVF = 3'd4;

   // escape phases
   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_HIGH = 2'd1;
   localparam logic [1:0] ESC_LOW  = 2'd2;

   // command kinds between front and back
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_PUSH = 2'd1;
   localparam logic [1:0] CMD_EMIT = 2'd2;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data;
      logic [SPC_W-1:0] cnt;     // store address on push, flush length on emit
      logic             last;
      logic [2:0]       status;
   } cmd_type;

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      case (b) inside
         [8'h30:8'h39]: r = {1'b1, 4'(b - 8'h30)};
         [8'h41:8'h46]: r = {1'b1, 4'(b - 8'h37)};
         [8'h61:8'h66]: r = {1'b1, 4'(b - 8'h57)};
         default:       r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_white(input logic [7:0] b);
      return b inside {CH_SPACE, [8'h09:8'h0D]};
   endfunction

endpackage

### design/updt_ram.sv
// ----------------------------------------------------------------------------
// updt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module updt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/updt_front.sv
// ----------------------------------------------------------------------------
// updt_front
// Accepts encoded bytes, tracks escape, length and trim state, and turns each
// item into one command for the back end.
// ----------------------------------------------------------------------------
module updt_front #(
   parameter int MAX_SPACE_RUN = updt_pkg::MAX_SPACE_RUN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_in_last,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic                   q_full,
   output logic                   cmd_push,
   output updt_pkg::cmd_type      cmd_data
);
   import updt_pkg::*;

   localparam logic [SPC_W-1:0] MAX_SC = SPC_W'(MAX_SPACE_RUN);

   logic [LEN_W-1:0] max_len_ff;
   logic [1:0]       esc_ff, esc_in;
   logic [3:0]       hi_ff, hi_in;
   logic             lead_ff, lead_in;
   logic [SPC_W-1:0] sc_ff, sc_in;
   logic [LEN_W-1:0] bc_ff, bc_in;
   logic [2:0]       err_ff, err_in;
   logic             stop_ff, stop_in;
   logic             ended_ff, ended_in;

   logic             take;
   logic [7:0]       dec;
   logic [4:0]       hx;
   cmd_type          cmd;
   logic             accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign cmd_push  = accept;
   assign cmd_data  = cmd;

   always_comb begin
      esc_in   = esc_ff;
      hi_in    = hi_ff;
      lead_in  = lead_ff;
      sc_in    = sc_ff;
      bc_in    = bc_ff;
      err_in   = err_ff;
      stop_in  = stop_ff;
      ended_in = ended_ff;
      take     = 1'b0;
      dec      = req_in_byte;
      hx       = hex_decode(req_in_byte);
      cmd      = '0;
      cmd.kind = CMD_NONE;

      // length check overrides every other error
      if (bc_ff >= max_len_ff) begin
         err_in  = ST_TOO_LONG;
         stop_in = 1'b1;
         sc_in   = '0;
      end else begin
         bc_in = bc_ff + 1'b1;
      end

      if (err_in == ST_OK && !ended_in) begin
         if (req_in_byte == 8'h00) begin
            ended_in = 1'b1;
            if (esc_in != ESC_NONE) begin
               err_in  = ST_CUT_ESC;
               stop_in = 1'b1;
               sc_in   = '0;
            end
         end else if (esc_in == ESC_NONE) begin
            if (req_in_byte == CH_PLUS) begin
               take = 1'b1;
               dec  = CH_SPACE;
            end else if (req_in_byte == CH_PERCENT) begin
               esc_in = ESC_HIGH;
            end else begin
               take = 1'b1;
            end
         end else if (!hx[4]) begin
            err_in  = ST_BAD_HEX;
            stop_in = 1'b1;
            sc_in   = '0;
         end else if (esc_in == ESC_HIGH) begin
            hi_in  = hx[3:0];
            esc_in = ESC_LOW;
         end else begin
            esc_in = ESC_NONE;
            take   = 1'b1;
            dec    = {hi_ff, hx[3:0]};
         end
      end

      if (take && !stop_in) begin
         if (dec == 8'h00) begin
            stop_in = 1'b1;
            sc_in   = '0;
         end else if (is_white(dec)) begin
            if (lead_in) begin
               if (sc_in < MAX_SC) begin
                  cmd.kind = CMD_PUSH;
                  cmd.data = dec;
                  cmd.cnt  = sc_in;
                  sc_in    = sc_in + 1'b1;
               end else begin
                  if (err_in == ST_OK) begin
                     err_in = ST_SPACE_OVF;
                  end
                  stop_in = 1'b1;
                  sc_in   = '0;
               end
            end
         end else begin
            cmd.kind = CMD_EMIT;
            cmd.data = dec;
            cmd.cnt  = sc_in;
            sc_in    = '0;
            lead_in  = 1'b1;
         end
      end

      if (req_in_last) begin
         if (err_in == ST_OK && esc_in != ESC_NONE) begin
            err_in = ST_CUT_ESC;
         end
         cmd.last   = 1'b1;
         cmd.status = err_in;
         // string done: back to the idle state for the next one
         esc_in   = ESC_NONE;
         hi_in    = '0;
         lead_in  = 1'b0;
         sc_in    = '0;
         bc_in    = '0;
         err_in   = ST_OK;
         stop_in  = 1'b0;
         ended_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
         esc_ff     <= ESC_NONE;
         hi_ff      <= '0;
         lead_ff    <= 1'b0;
         sc_ff      <= '0;
         bc_ff      <= '0;
         err_ff     <= ST_OK;
         stop_ff    <= 1'b0;
         ended_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (accept) begin
            esc_ff   <= esc_in;
            hi_ff    <= hi_in;
            lead_ff  <= lead_in;
            sc_ff    <= sc_in;
            bc_ff    <= bc_in;
            err_ff   <= err_in;
            stop_ff  <= stop_in;
            ended_ff <= ended_in;
         end
      end
   end

endmodule

### design/updt_queue.sv
// ----------------------------------------------------------------------------
// updt_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module updt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  updt_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output updt_pkg::cmd_type head
);
   import updt_pkg::*;

   cmd_type            entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

### design/updt_back.sv
// ----------------------------------------------------------------------------
// updt_back
// Carries out queued commands: stores held whitespace, flushes it ahead of
// the next data byte and drives the result register.
// ----------------------------------------------------------------------------
module updt_back #(
   parameter int MAX_SPACE_RUN = updt_pkg::MAX_SPACE_RUN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  updt_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_has_byte,
   output logic              rsp_out_last,
   output logic [2:0]        rsp_out_status
);
   import updt_pkg::*;

   localparam int AW = (MAX_SPACE_RUN > 1) ? $clog2(MAX_SPACE_RUN) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FLUSH = 2'd1;
   localparam logic [1:0] S_BYTE  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [SPC_W-1:0] idx_ff, idx_in;
   cmd_type          cur_ff, cur_in;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_has_ff;
   logic             rsp_last_ff;
   logic [2:0]       rsp_status_ff;

   logic             out_free;
   logic             ld;
   logic [7:0]       ld_byte;
   logic             ld_has;
   logic             ld_last;
   logic [2:0]       ld_status;

   logic             wr_en, rd_en;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       rd_data;
   logic [SPC_W-1:0] idx_next;

   updt_ram #(
      .WIDTH (8),
      .DEPTH (MAX_SPACE_RUN)
   ) u_space_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (q_head.cnt[AW-1:0]),
      .wr_data (q_head.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_next = idx_ff + 1'b1;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      q_pop     = 1'b0;
      ld        = 1'b0;
      ld_byte   = '0;
      ld_has    = 1'b0;
      ld_last   = 1'b0;
      ld_status = ST_OK;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               case (q_head.kind)
                  CMD_EMIT: begin
                     if (q_head.cnt == '0) begin
                        ld        = 1'b1;
                        ld_byte   = q_head.data;
                        ld_has    = 1'b1;
                        ld_last   = q_head.last;
                        ld_status = q_head.status;
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = '0;
                        state_in = S_FLUSH;
                     end
                  end
                  CMD_PUSH: begin
                     wr_en = 1'b1;
                     if (q_head.last) begin
                        ld        = 1'b1;
                        ld_last   = 1'b1;
                        ld_status = q_head.status;
                     end
                  end
                  default: begin
                     if (q_head.last) begin
                        ld        = 1'b1;
                        ld_last   = 1'b1;
                        ld_status = q_head.status;
                     end
                  end
               endcase
            end
         end
         S_FLUSH: begin
            // read data holds the held byte at idx_ff
            if (out_free) begin
               ld      = 1'b1;
               ld_byte = rd_data;
               ld_has  = 1'b1;
               if (idx_next == cur_ff.cnt) begin
                  state_in = S_BYTE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_next[AW-1:0];
                  idx_in  = idx_next;
               end
            end
         end
         S_BYTE: begin
            if (out_free) begin
               ld        = 1'b1;
               ld_byte   = cur_ff.data;
               ld_has    = 1'b1;
               ld_last   = cur_ff.last;
               ld_status = cur_ff.status;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         rsp_byte_ff   <= ld_byte;
         rsp_has_ff    <= ld_has;
         rsp_last_ff   <= ld_last;
         rsp_status_ff <= ld_status;
      end
      cur_ff <= cur_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_out_has_byte = rsp_has_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_out_status   = rsp_status_ff;

endmodule

### design/url_percent_decoder_trim.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_trim
// Streaming URL percent decoder with leading and trailing whitespace trim.
//
// The req_ channel takes one encoded byte per item, req_in_last closing the
// string. The rsp_ channel returns decoded bytes; the closing result of a
// string has rsp_out_last set and carries the status, and has no byte when
// the string ends without sending one. The csr_ port writes the maximum
// string length at any idle moment.
// An item is taken every cycle while the command queue has room. A byte that
// is sent directly passes through the command queue and the result register
// before it is presented on rsp_. A byte that releases held whitespace bytes
// occupies the back end for the read set-up, then for each held byte in
// turn and then for the byte itself.
// When rsp_stall is high the result register holds, the back end waits, the
// four-entry queue fills and req_stall rises.
// Reset returns the length limit to 1024 and empties the queue and the result
// register; the whitespace RAM needs no clearing.
// ----------------------------------------------------------------------------
module url_percent_decoder_trim #(
   parameter int MAX_SPACE_RUN = updt_pkg::MAX_SPACE_RUN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_has_byte,
   output logic        rsp_out_last,
   output logic [2:0]  rsp_out_status,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import updt_pkg::*;

   cmd_type cmd_data;
   cmd_type q_head;
   logic    cmd_push;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;

   updt_front #(
      .MAX_SPACE_RUN (MAX_SPACE_RUN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_data)
   );

   updt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   updt_back #(
      .MAX_SPACE_RUN (MAX_SPACE_RUN)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_has_byte (rsp_out_has_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_out_status   (rsp_out_status)
   );

endmodule
